/* hw/rtl/skx_pkg.sv */
// Shared types and constants of the splitmix keystream XOR block.
// No dependencies; every other file of the block imports this package.
package skx_pkg;

  // splitmix64 generator constants
  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // one classified request as it travels from front to back
  typedef struct packed {
    logic [7:0] data;   // byte to transform
    logic       start;  // first byte of a fragment: reload from seed
    logic       draw;   // byte position 0: a new lane is needed
    logic [2:0] pos;    // lane byte used by this request
  } skx_entry_t;

  // back-end sequencer
  typedef enum logic [2:0] {
    B_IDLE,
    B_LOAD,
    B_MUL1,
    B_MUL2,
    B_EMIT
  } back_state_t;

  // iterative 64-bit multiplier, low half of the product
  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_LL,
    MUL_LH,
    MUL_HL
  } mul_state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } mul_rsp_t;

endpackage

/* hw/rtl/skx_front.sv */
// Front end: accepts input requests and tags each with its lane byte position.
// Depends on skx_pkg.
module skx_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] data_byte
  input  logic               s_tuser,   // [0] start_req
  input  logic               q_ready,
  output logic               push,
  output skx_pkg::skx_entry_t push_entry
);
  import skx_pkg::*;

  logic [2:0] pos;
  logic [2:0] cur_pos;

  // take a request whenever the queue has room
  assign s_tready = q_ready;
  assign push     = s_tvalid && q_ready;

  // classify: a start restarts the lane, position 0 draws a lane
  always_comb begin
    cur_pos          = s_tuser ? 3'd0 : pos;
    push_entry.data  = s_tdata;
    push_entry.start = s_tuser;
    push_entry.pos   = cur_pos;
    push_entry.draw  = (cur_pos == 3'd0);
  end

  // advance the byte position on every accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 3'd0;
    end else if (push) begin
      pos <= cur_pos + 3'd1;
    end
  end

endmodule

/* hw/rtl/skx_queue.sv */
// Short request queue between front and back, built from flip-flops.
// Depends on skx_pkg.
module skx_queue #(
  parameter int DEPTH = skx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  skx_pkg::skx_entry_t push_entry,
  output logic                ready,
  input  logic                pop,
  output logic                valid,
  output skx_pkg::skx_entry_t entry
);
  import skx_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  skx_entry_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign ready = (count != FULL);
  assign valid = (count != '0);
  assign entry = mem[rd_ptr];

  // store pushed requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // advance pointers and hold the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("queue fill count beyond depth");
  assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("queue popped while empty");
  assert property (@(posedge clk) disable iff (rst) push |-> count != FULL)
    else $error("queue pushed while full");

endmodule

/* hw/rtl/skx_mul64.sv */
// Iterative multiplier: low 64 bits of a 64x64 product from three 32x32 steps.
// Depends on skx_pkg.
module skx_mul64 (
  input  logic              clk,
  input  logic              rst,
  input  skx_pkg::mul_req_t req,
  output skx_pkg::mul_rsp_t rsp
);
  import skx_pkg::*;

  mul_state_t  state;
  mul_state_t  state_next;
  logic [63:0] a_op;
  logic [63:0] b_op;
  logic [63:0] acc;
  logic [31:0] x_sel;
  logic [31:0] y_sel;
  logic [63:0] prod;
  logic        done;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      MUL_IDLE: if (req.start) state_next = MUL_LL;
      MUL_LL:   state_next = MUL_LH;
      MUL_LH:   state_next = MUL_HL;
      MUL_HL:   state_next = MUL_IDLE;
      default:  state_next = MUL_IDLE;
    endcase
  end

  // pick the operand halves for this step
  always_comb begin
    unique case (state)
      MUL_LH: begin
        x_sel = a_op[31:0];
        y_sel = b_op[63:32];
      end
      MUL_HL: begin
        x_sel = a_op[63:32];
        y_sel = b_op[31:0];
      end
      default: begin
        x_sel = a_op[31:0];
        y_sel = b_op[31:0];
      end
    endcase
  end

  assign prod = 64'(x_sel) * 64'(y_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MUL_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == MUL_HL);
    end
  end

  // latch operands, then accumulate the partial products
  always_ff @(posedge clk) begin
    if (state == MUL_IDLE && req.start) begin
      a_op <= req.a;
      b_op <= req.b;
    end
    if (state == MUL_LL) begin
      acc <= prod;
    end else if (state == MUL_LH || state == MUL_HL) begin
      acc[63:32] <= acc[63:32] + prod[31:0];
    end
  end

  assign rsp.done   = done;
  assign rsp.result = acc;

  assert property (@(posedge clk) disable iff (rst) done |-> state == MUL_IDLE)
    else $error("multiplier result flagged while busy");

endmodule

/* hw/rtl/skx_back.sv */
// Back end: runs the splitmix64 generator, XORs bytes and holds the output register.
// Depends on skx_pkg; drives the shared skx_mul64 unit.
module skx_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [63:0]         cfg_wr_data,
  input  logic                q_valid,
  input  skx_pkg::skx_entry_t q_entry,
  output logic                pop,
  output skx_pkg::mul_req_t   mul_req,
  input  skx_pkg::mul_rsp_t   mul_rsp,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata
);
  import skx_pkg::*;

  back_state_t state;
  back_state_t state_next;
  logic [63:0] key_seed;
  logic [63:0] gen_state;
  logic [63:0] lane_word;
  skx_entry_t  cur;
  logic [7:0]  out_byte;

  logic        out_free;
  logic        load_direct;
  logic        load_emit;
  logic [63:0] gen_adv;
  logic [63:0] z0;
  logic [63:0] z1;
  logic [63:0] lane_fin;
  logic [7:0]  lane_byte;

  assign out_free = !m_tvalid || m_tready;

  // generator arithmetic around the multiplier
  always_comb begin
    gen_adv   = (cur.start ? key_seed : gen_state) + GOLDEN_GAMMA;
    z0        = gen_adv ^ (gen_adv >> 30);
    z1        = mul_rsp.result ^ (mul_rsp.result >> 27);
    lane_fin  = mul_rsp.result ^ (mul_rsp.result >> 31);
    lane_byte = lane_word[{q_entry.pos, 3'b000} +: 8];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (q_valid && q_entry.draw) state_next = B_LOAD;
      B_LOAD:  state_next = B_MUL1;
      B_MUL1:  if (mul_rsp.done) state_next = B_MUL2;
      B_MUL2:  if (mul_rsp.done) state_next = B_EMIT;
      B_EMIT:  if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop           = 1'b0;
    load_direct   = 1'b0;
    load_emit     = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = z1;
    mul_req.b     = MIX_MUL_B;
    unique case (state)
      B_IDLE: begin
        pop         = q_valid && (q_entry.draw || out_free);
        load_direct = q_valid && !q_entry.draw && out_free;
      end
      B_LOAD: begin
        mul_req.start = 1'b1;
        mul_req.a     = z0;
        mul_req.b     = MIX_MUL_A;
      end
      B_MUL1: begin
        mul_req.start = mul_rsp.done;
      end
      B_EMIT: begin
        load_emit = out_free;
      end
      default: begin
      end
    endcase
  end

  // control and generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      m_tvalid  <= 1'b0;
      key_seed  <= '0;
      gen_state <= '0;
    end else begin
      state <= state_next;
      if (load_direct || load_emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wr_en) begin
        key_seed <= cfg_wr_data;
      end
      if (state == B_LOAD) begin
        gen_state <= gen_adv;
      end
    end
  end

  // hold the request being drawn for, the lane and the output byte
  always_ff @(posedge clk) begin
    if (pop && q_entry.draw) begin
      cur <= q_entry;
    end
    if (state == B_MUL2 && mul_rsp.done) begin
      lane_word <= lane_fin;
    end
    if (load_direct) begin
      out_byte <= q_entry.data ^ lane_byte;
    end else if (load_emit) begin
      out_byte <= cur.data ^ lane_word[7:0];
    end
  end

  assign m_tdata = out_byte;

  assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == B_MUL1 || state == B_MUL2))
    else $error("multiplier result arrived with no draw in progress");
  assert property (@(posedge clk) disable iff (rst)
    (pop && q_entry.draw) |=> state == B_LOAD)
    else $error("lane draw request did not start the generator");
  assert property (@(posedge clk) disable iff (rst)
    (state != B_IDLE) |-> !pop)
    else $error("queue popped during a lane draw");

endmodule

/* hw/rtl/splitmix_keystream_xor_top.sv */
// Bytes inside a lane pass through the request queue and the output register; a byte at a lane
// boundary (every eighth byte, or a start byte) also waits for the generator, which runs the two
// 64-bit multiplies of the splitmix64 mix, each three 32x32 steps on one multiplier.
// During a lane draw the back end pops nothing; the queue takes bytes while it has room.
// Reset (synchronous, rst high) clears seed, generator, byte position and queue.
// Top level: front end, request queue, back end and shared multiplier; uses skx_pkg.
module splitmix_keystream_xor_top #(
  parameter int QUEUE_DEPTH = skx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,  // key_seed
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // [7:0] data_byte
  input  logic        s_tuser,      // [0] start_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata       // [7:0] out_byte
);
  import skx_pkg::*;

  logic       push;
  skx_entry_t push_entry;
  logic       q_ready;
  logic       q_valid;
  skx_entry_t q_entry;
  logic       pop;
  mul_req_t   mul_req;
  mul_rsp_t   mul_rsp;

  skx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .q_ready    (q_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  skx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .ready      (q_ready),
    .pop        (pop),
    .valid      (q_valid),
    .entry      (q_entry)
  );

  skx_mul64 u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  skx_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .pop         (pop),
    .mul_req     (mul_req),
    .mul_rsp     (mul_rsp),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule
